/* rtl/gamepad_change_command_encoder_core_defines.svh */
// ----------------------------------------------------------------------------
// gamepad_change_command_encoder_core_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_CHANGE_COMMAND_ENCODER_CORE_DEFINES_SVH
`define GAMEPAD_CHANGE_COMMAND_ENCODER_CORE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define GCCE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gcce: assertion failed");

// Check a property at every clock edge, reset included.
`define GCCE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("gcce: assertion failed");

`endif

/* rtl/gcce_pkg.sv */
// ----------------------------------------------------------------------------
// gcce_pkg
// Types and constants shared by the command encoder controller and datapath.
// ----------------------------------------------------------------------------
package gcce_pkg;

  localparam int NUM_CHAN = 12;
  localparam int NUM_PEND = 14;
  localparam int IDX_W    = 4;

  // Slots in the pending vector beyond the digital channels
  localparam logic [IDX_W-1:0] IDX_STICK_X = 4'd12;
  localparam logic [IDX_W-1:0] IDX_STICK_Y = 4'd13;

  localparam logic [7:0] TRIG_FULL    = 8'd255;
  localparam logic [7:0] STICK_X_BASE = 8'd45;
  localparam logic [7:0] STICK_Y_BASE = 8'd96;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic load;  // capture snapshot, build pending vector
    logic pop;   // move the next pending word to the output register
  } cmd_t;

  typedef struct packed {
    logic load_any;   // incoming snapshot causes at least one word
    logic pend_last;  // at most one word still pending
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage

/* rtl/gcce_ctrl.sv */
// ----------------------------------------------------------------------------
// gcce_ctrl
// Controller: accepts a snapshot in idle, then steps the datapath word by word.
// ----------------------------------------------------------------------------
module gcce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gcce_pkg::sts_t sts,
  output gcce_pkg::cmd_t cmd
);
  import gcce_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.load_any) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free && sts.pend_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.pop = sts.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

/* rtl/gcce_dp.sv */
// ----------------------------------------------------------------------------
// gcce_dp
// Datapath: previous snapshot, pending word vector, stick bytes, output register.
// ----------------------------------------------------------------------------
module gcce_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  gcce_pkg::cmd_t     cmd,
  output gcce_pkg::sts_t     sts,
  input  logic [15:0]        in_button_word,
  input  logic [7:0]         in_left_trigger,
  input  logic [7:0]         in_right_trigger,
  input  logic signed [15:0] in_left_stick_x,
  input  logic signed [15:0] in_right_stick_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_command_byte,
  output logic               out_last_of_run
);
  import gcce_pkg::*;

  logic [NUM_CHAN-1:0] prev_dig_r;
  logic [15:0]         prev_x_r;
  logic [15:0]         prev_y_r;
  logic [NUM_PEND-1:0] pend_r, pend_nxt;
  logic [7:0]          bx_r, by_r;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  logic [NUM_CHAN-1:0] now_dig;
  logic [NUM_PEND-1:0] load_pend;
  logic signed [7:0]   qx, qy;
  logic [7:0]          bx, by;
  logic [IDX_W-1:0]    sel_idx;
  logic [NUM_PEND-1:0] sel_hot, pend_rest;
  logic [7:0]          sel_byte;

  // Digital channels in emit order
  always_comb begin
    now_dig[0]  = in_button_word[12];
    now_dig[1]  = in_button_word[13];
    now_dig[2]  = in_button_word[14];
    now_dig[3]  = in_button_word[15];
    now_dig[4]  = in_button_word[8];
    now_dig[5]  = in_button_word[9];
    now_dig[6]  = (in_left_trigger == TRIG_FULL);
    now_dig[7]  = (in_right_trigger == TRIG_FULL);
    now_dig[8]  = in_button_word[3];
    now_dig[9]  = in_button_word[0];
    now_dig[10] = in_button_word[2];
    now_dig[11] = in_button_word[1];
  end

  // Divide by 1024 / 2048 truncating toward zero: floor, then round a
  // negative value with a nonzero remainder up by one.
  always_comb begin
    qx = {{2{in_left_stick_x[15]}}, in_left_stick_x[15:10]}
         + {7'd0, in_left_stick_x[15] & (|in_left_stick_x[9:0])};
    qy = {{3{in_right_stick_y[15]}}, in_right_stick_y[15:11]}
         + {7'd0, in_right_stick_y[15] & (|in_right_stick_y[10:0])};
    bx = 8'(qx) + STICK_X_BASE;
    by = 8'(qy) + STICK_Y_BASE;
  end

  assign load_pend = {(in_right_stick_y != prev_y_r),
                      (in_left_stick_x != prev_x_r),
                      now_dig & ~prev_dig_r};

  // Lowest pending slot goes out first
  always_comb begin
    sel_idx = '0;
    for (int i = NUM_PEND - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
    sel_hot   = NUM_PEND'(1) << sel_idx;
    pend_rest = pend_r & ~sel_hot;
    case (sel_idx)
      IDX_STICK_X: sel_byte = bx_r;
      IDX_STICK_Y: sel_byte = by_r;
      default:     sel_byte = 8'(sel_idx) + 8'd1;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (cmd.load) begin
      pend_nxt = load_pend;
    end else if (cmd.pop) begin
      pend_nxt = pend_rest;
    end
  end

  assign sts.load_any  = |load_pend;
  assign sts.pend_last = (pend_rest == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dig_r  <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (cmd.load) begin
        prev_dig_r <= now_dig;
        prev_x_r   <= in_left_stick_x;
        prev_y_r   <= in_right_stick_y;
      end
      if (cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx_r <= bx;
      by_r <= by;
    end
    if (cmd.pop) begin
      out_byte_r <= sel_byte;
      out_last_r <= (pend_rest == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_byte = out_byte_r;
  assign out_last_of_run  = out_last_r;

endmodule

/* rtl/gamepad_change_command_encoder_core.sv */
// ----------------------------------------------------------------------------
// gamepad_change_command_encoder_core
// Compares each gamepad snapshot with the previous one and emits a command
// word for every newly pressed channel and every stick change.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Word
//  in_      sink       in_valid/in_stall  button word, triggers, two sticks
//  out_     source     out_valid/out_stall command byte, last-of-run flag
//
//  A snapshot is taken while the controller is idle; it then yields n words
//  (0..14), one per cycle from the single output register while out_ does
//  not stall. in_stall stays high while words of the current snapshot are
//  pending; the last word may still sit in the output register when the
//  next snapshot is taken. A stall on out_ holds the output register and
//  the pending vector. Reset clears the stored snapshot to all zeros and
//  empties the output.
//
module gamepad_change_command_encoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_button_word,
  input  logic [7:0]         in_left_trigger,
  input  logic [7:0]         in_right_trigger,
  input  logic signed [15:0] in_left_stick_x,
  input  logic signed [15:0] in_right_stick_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_command_byte,
  output logic               out_last_of_run
);
  import gcce_pkg::*;

  // Command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // Controller: idle until a snapshot arrives, then drain pending words
  gcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hold previous snapshot, build pending words, drive output
  gcce_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_button_word   (in_button_word),
    .in_left_trigger  (in_left_trigger),
    .in_right_trigger (in_right_trigger),
    .in_left_stick_x  (in_left_stick_x),
    .in_right_stick_y (in_right_stick_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_byte (out_command_byte),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

/* rtl/gcce_checker.sv */
// ----------------------------------------------------------------------------
// gcce_checker
// Port-level assertions for the command encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "gamepad_change_command_encoder_core_defines.svh"

module gcce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_command_byte,
  input logic        out_last_of_run
);

  // A stalled word stays put
  `GCCE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `GCCE_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_command_byte))
  // While a run is pending, a word shows up on the next cycle
  `GCCE_ASSERT(a_run_feeds_out, in_stall |=> out_valid)
  // A word that is not last means more words follow, so the input waits
  `GCCE_ASSERT_ALWAYS(a_mid_run_stall, rst_n && out_valid && !out_last_of_run |-> in_stall)

endmodule

bind gamepad_change_command_encoder_core gcce_checker u_gcce_checker (.*);
